### rtl/rbd_pkg.sv
// Shared types, constants and helpers for the reverse block delay.
`timescale 1ns / 1ps

package rbd_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int BLOCK_W    = 18;
    localparam int FB_W       = 15;
    localparam int MIX_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;
    localparam int SAT_W      = 48;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_LEVEL     = 2'd2;

    localparam logic [BLOCK_W-1:0] BLOCK_SIZE_RST    = 18'd24000;
    localparam logic [FB_W-1:0]    FEEDBACK_GAIN_RST = 15'd9830;
    localparam logic [MIX_W-1:0]   MIX_LEVEL_RST     = 16'd16384;

    // Unity in Q1.15
    localparam logic [MIX_W:0] UNITY_Q15 = 17'd32768;

    localparam logic signed [SAT_W-1:0] SAMPLE_MAX = SAT_W'((2 ** (SAMPLE_W - 1)) - 1);
    localparam logic signed [SAT_W-1:0] SAMPLE_MIN = -SAMPLE_MAX - SAT_W'(1);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] in_left;
        logic signed [SAMPLE_W-1:0] in_right;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_left;
        logic signed [SAMPLE_W-1:0] out_right;
    } out_word_t;

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [SAT_W-1:0] v
    );
        logic signed [SAMPLE_W-1:0] r;
        if (v > SAMPLE_MAX) begin
            r = SAMPLE_MAX[SAMPLE_W-1:0];
        end else if (v < SAMPLE_MIN) begin
            r = SAMPLE_MIN[SAMPLE_W-1:0];
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/reverse_block_delay.sv
// Reverse block delay: records with feedback, plays each block backwards, mixes with dry.
// Stages: read-return, product and output register; m_ready back-pressure can hold each.
// Input: a new word is accepted only after the previous one leaves the read-return stage;
//   the store feedback loop (write and read issued on accept, registered read) sets this.
// Reset: pointers, fill count, block flag, last wet samples and registers return to
//   defaults; store contents are not cleared.
`timescale 1ns / 1ps

module reverse_block_delay #(
    parameter int BUFFER_DEPTH = 131072
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  rbd_pkg::in_word_t                    s_data,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output rbd_pkg::out_word_t                   m_data,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rbd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rbd_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int SW    = rbd_pkg::SAMPLE_W;
    localparam int AW    = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int CMP_W = (CNT_W > rbd_pkg::BLOCK_W) ? CNT_W : rbd_pkg::BLOCK_W;
    localparam int PW    = SW + rbd_pkg::MIX_W + 2;
    localparam int FPW   = SW + rbd_pkg::FB_W + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(BUFFER_DEPTH - 1);

    // Configuration registers
    logic [rbd_pkg::BLOCK_W-1:0] block_size_reg;
    logic [rbd_pkg::FB_W-1:0]    feedback_gain_reg;
    logic [rbd_pkg::MIX_W-1:0]   mix_level_reg;

    // Loop state
    logic [AW-1:0]          wp_reg, rp_reg;
    logic [CNT_W-1:0]       fill_reg;
    logic                   block_ready_reg;
    logic signed [SW-1:0]   last_wet_l_reg, last_wet_r_reg;

    // Read-return stage
    logic                   b_valid_reg;
    logic                   b_fwd_reg;
    logic                   b_use_wet_reg;
    logic signed [SW-1:0]   b_dry_l_reg, b_dry_r_reg;
    logic signed [SW-1:0]   b_rec_l_reg, b_rec_r_reg;

    // Product stage
    logic                   p_valid_reg;
    logic signed [PW-1:0]   p_dry_l_reg, p_dry_r_reg, p_wet_l_reg, p_wet_r_reg;

    // Output register
    logic                   m_valid_reg;
    rbd_pkg::out_word_t     m_data_reg;

    logic                   s_accept, b_adv, p_adv;
    logic [CMP_W-1:0]       bs_ext, bs_eff, fill_inc;
    logic                   boundary;
    logic [AW-1:0]          rp_eff;
    logic signed [FPW-1:0]  fb_prod_l, fb_prod_r;
    logic signed [SW-1:0]   rec_l, rec_r;
    logic [2*SW-1:0]        rd_data;
    logic signed [SW-1:0]   wet_l, wet_r;
    logic [rbd_pkg::MIX_W:0] mix_eff, dry_gain;
    logic signed [PW-1:0]   prod_dry_l, prod_dry_r, prod_wet_l, prod_wet_r;
    logic signed [rbd_pkg::SAT_W-1:0] sum_l, sum_r;

    // Take register writes only with the pipeline empty; hold input while one waits
    assign cfg_ready = !b_valid_reg && !p_valid_reg && !m_valid_reg;
    assign s_ready   = !b_valid_reg && !cfg_valid;
    assign s_accept  = s_valid && s_ready;
    assign p_adv     = p_valid_reg && (!m_valid_reg || m_ready);
    assign b_adv     = b_valid_reg && (!p_valid_reg || p_adv);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_size_reg    <= rbd_pkg::BLOCK_SIZE_RST;
            feedback_gain_reg <= rbd_pkg::FEEDBACK_GAIN_RST;
            mix_level_reg     <= rbd_pkg::MIX_LEVEL_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rbd_pkg::CFG_BLOCK_SIZE:    block_size_reg    <= cfg_data;
                rbd_pkg::CFG_FEEDBACK_GAIN: feedback_gain_reg <= cfg_data[rbd_pkg::FB_W-1:0];
                rbd_pkg::CFG_MIX_LEVEL:     mix_level_reg     <= cfg_data[rbd_pkg::MIX_W-1:0];
                default: ;
            endcase
        end
    end

    // Record path: input plus scaled last wet, clamp block size, find block edge
    always_comb begin
        fb_prod_l = last_wet_l_reg * $signed({1'b0, feedback_gain_reg});
        fb_prod_r = last_wet_r_reg * $signed({1'b0, feedback_gain_reg});
        rec_l = rbd_pkg::sat_sample(rbd_pkg::SAT_W'(s_data.in_left)
                                  + rbd_pkg::SAT_W'(fb_prod_l >>> 15));
        rec_r = rbd_pkg::sat_sample(rbd_pkg::SAT_W'(s_data.in_right)
                                  + rbd_pkg::SAT_W'(fb_prod_r >>> 15));

        bs_ext = CMP_W'(block_size_reg);
        if (bs_ext == '0) begin
            bs_eff = CMP_W'(1);
        end else if (bs_ext > CMP_W'(BUFFER_DEPTH)) begin
            bs_eff = CMP_W'(BUFFER_DEPTH);
        end else begin
            bs_eff = bs_ext;
        end
        fill_inc = CMP_W'(fill_reg) + CMP_W'(1);
        boundary = (fill_inc >= bs_eff);
        rp_eff   = boundary ? wp_reg : rp_reg;
    end

    rbd_ram #(
        .WIDTH (2 * SW),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (s_accept),
        .wr_addr (wp_reg),
        .wr_data ({rec_l, rec_r}),
        .rd_en   (s_accept),
        .rd_addr (rp_eff),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg          <= '0;
            rp_reg          <= '0;
            fill_reg        <= '0;
            block_ready_reg <= 1'b0;
        end else if (s_accept) begin
            wp_reg   <= (wp_reg == LAST_ADDR) ? '0 : wp_reg + AW'(1);
            fill_reg <= boundary ? '0 : fill_inc[CNT_W-1:0];
            if (boundary || block_ready_reg) begin
                block_ready_reg <= 1'b1;
                rp_reg <= (rp_eff == '0) ? LAST_ADDR : rp_eff - AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (s_accept) begin
            b_valid_reg <= 1'b1;
        end else if (b_adv) begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            b_fwd_reg     <= (rp_eff == wp_reg);
            b_use_wet_reg <= boundary || block_ready_reg;
            b_dry_l_reg   <= s_data.in_left;
            b_dry_r_reg   <= s_data.in_right;
            b_rec_l_reg   <= rec_l;
            b_rec_r_reg   <= rec_r;
        end
    end

    // Wet select: forward the word written in the same cycle, zero before first block
    always_comb begin
        if (!b_use_wet_reg) begin
            wet_l = '0;
            wet_r = '0;
        end else if (b_fwd_reg) begin
            wet_l = b_rec_l_reg;
            wet_r = b_rec_r_reg;
        end else begin
            wet_l = rd_data[2*SW-1:SW];
            wet_r = rd_data[SW-1:0];
        end
        mix_eff    = ({1'b0, mix_level_reg} > rbd_pkg::UNITY_Q15)
                   ? rbd_pkg::UNITY_Q15 : {1'b0, mix_level_reg};
        dry_gain   = rbd_pkg::UNITY_Q15 - mix_eff;
        prod_dry_l = b_dry_l_reg * $signed({1'b0, dry_gain});
        prod_dry_r = b_dry_r_reg * $signed({1'b0, dry_gain});
        prod_wet_l = wet_l * $signed({1'b0, mix_eff});
        prod_wet_r = wet_r * $signed({1'b0, mix_eff});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_wet_l_reg <= '0;
            last_wet_r_reg <= '0;
        end else if (b_adv && b_use_wet_reg) begin
            last_wet_l_reg <= wet_l;
            last_wet_r_reg <= wet_r;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (b_adv) begin
            p_valid_reg <= 1'b1;
        end else if (p_adv) begin
            p_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_adv) begin
            p_dry_l_reg <= prod_dry_l;
            p_dry_r_reg <= prod_dry_r;
            p_wet_l_reg <= prod_wet_l;
            p_wet_r_reg <= prod_wet_r;
        end
    end

    always_comb begin
        sum_l = rbd_pkg::SAT_W'(p_dry_l_reg) + rbd_pkg::SAT_W'(p_wet_l_reg);
        sum_r = rbd_pkg::SAT_W'(p_dry_r_reg) + rbd_pkg::SAT_W'(p_wet_r_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_adv) begin
            m_data_reg.out_left  <= rbd_pkg::sat_sample(sum_l >>> 15);
            m_data_reg.out_right <= rbd_pkg::sat_sample(sum_r >>> 15);
        end
    end

    // Two accepted words are never adjacent: the feedback read must return first
    a_accept_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_accept)
        else $error("input words accepted on consecutive cycles");

    // Last wet samples move only when a word leaves the read-return stage
    a_last_wet_update: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (!$stable(last_wet_l_reg) || !$stable(last_wet_r_reg)))
        |-> $past(b_adv))
        else $error("last wet sample changed without a word advancing");

    // Fill count stays below the buffer depth, the upper clamp of the block size
    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(fill_reg) < CMP_W'(BUFFER_DEPTH))
        else $error("fill count out of range");

endmodule

### rtl/rbd_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module rbd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 131072
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### dv/tb.sv
// Self-checking testbench for the reverse block delay: random traffic, predicted mix per word.
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH       = 256;
    localparam int LATENCY     = 2;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEM_TARGET = 550;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [rbd_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [rbd_pkg::SAMPLE_W-1:0]  PEAK_POS  = 24'h7FFFFF;
    localparam logic [rbd_pkg::SAMPLE_W-1:0]  PEAK_NEG  = 24'h800000;

    // Tracks the recording store, the reversed playback and the dry/wet mix.
    class reverse_delay_board;
        int unsigned depth;
        int left_mem[];
        int right_mem[];
        bit written[];
        int unsigned wr_ptr;
        int unsigned rd_ptr;
        int unsigned fill;
        bit playing;
        longint wet_hist_l;
        longint wet_hist_r;
        logic [rbd_pkg::BLOCK_W-1:0] block_len;
        logic [rbd_pkg::FB_W-1:0] fb_gain;
        logic [rbd_pkg::MIX_W-1:0] mix_level;
        rbd_pkg::out_word_t pending_out[$];
        int errors;

        function new(int unsigned d);
            depth = d;
            left_mem = new[d];
            right_mem = new[d];
            written = new[d];
            block_len = rbd_pkg::BLOCK_SIZE_RST;
            fb_gain = rbd_pkg::FEEDBACK_GAIN_RST;
            mix_level = rbd_pkg::MIX_LEVEL_RST;
        endfunction

        static function longint clip(longint v);
            if (v > 64'sd8388607) return 64'sd8388607;
            if (v < -64'sd8388608) return -64'sd8388608;
            return v;
        endfunction

        static function longint blend(longint dry, longint wet, longint m);
            return clip((dry * (64'sd32768 - m) + wet * m) >>> 15);
        endfunction

        function int unsigned span(logic [rbd_pkg::BLOCK_W-1:0] len);
            if (len == 0) return 1;
            if (len > depth) return depth;
            return 32'(len);
        endfunction

        // True when playback up to the next boundary only touches recorded entries.
        function bit fits(logic [rbd_pkg::BLOCK_W-1:0] len);
            int unsigned p;
            int unsigned reads;
            if (!playing) return 1;
            reads = (span(len) > fill + 1) ? span(len) - fill - 1 : 0;
            p = rd_ptr;
            repeat (reads) begin
                if (!written[p]) return 0;
                p = (p == 0) ? depth - 1 : p - 1;
            end
            return 1;
        endfunction

        function void set_reg(logic [rbd_pkg::CFG_IDX_W-1:0] idx,
                              logic [rbd_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                rbd_pkg::CFG_BLOCK_SIZE:    block_len = data[rbd_pkg::BLOCK_W-1:0];
                rbd_pkg::CFG_FEEDBACK_GAIN: fb_gain = data[rbd_pkg::FB_W-1:0];
                rbd_pkg::CFG_MIX_LEVEL:     mix_level = data[rbd_pkg::MIX_W-1:0];
                default: ;
            endcase
        endfunction

        function void record_word(rbd_pkg::in_word_t w);
            longint dry_l;
            longint dry_r;
            longint fb;
            longint m;
            longint wet_l;
            longint wet_r;
            rbd_pkg::out_word_t e;
            dry_l = longint'(w.in_left);
            dry_r = longint'(w.in_right);
            fb = longint'(fb_gain);
            if (mix_level > 16'd32768) m = 32768;
            else m = longint'(mix_level);
            wet_l = 0;
            wet_r = 0;
            left_mem[wr_ptr] = int'(clip(dry_l + ((wet_hist_l * fb) >>> 15)));
            right_mem[wr_ptr] = int'(clip(dry_r + ((wet_hist_r * fb) >>> 15)));
            written[wr_ptr] = 1'b1;
            fill++;
            // jump playback to the newest entry at each block boundary
            if (fill >= span(block_len)) begin
                playing = 1'b1;
                rd_ptr = wr_ptr;
                fill = 0;
            end
            wr_ptr = (wr_ptr + 1 >= depth) ? 0 : wr_ptr + 1;
            if (playing) begin
                wet_l = longint'(left_mem[rd_ptr]);
                wet_r = longint'(right_mem[rd_ptr]);
                wet_hist_l = wet_l;
                wet_hist_r = wet_r;
                rd_ptr = (rd_ptr == 0) ? depth - 1 : rd_ptr - 1;
            end
            e.out_left = rbd_pkg::SAMPLE_W'(blend(dry_l, wet_l, m));
            e.out_right = rbd_pkg::SAMPLE_W'(blend(dry_r, wet_r, m));
            pending_out.push_back(e);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) $display("%s", msg);
        endfunction

        function void check_word(rbd_pkg::out_word_t got);
            rbd_pkg::out_word_t e;
            if (pending_out.size() == 0) begin
                flag($sformatf("result word %h with nothing expected", got));
                return;
            end
            e = pending_out.pop_front();
            if (got.out_left !== e.out_left)
                flag($sformatf("out_left: expected %0d, got %0d", e.out_left, got.out_left));
            if (got.out_right !== e.out_right)
                flag($sformatf("out_right: expected %0d, got %0d", e.out_right, got.out_right));
        endfunction
    endclass

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    rbd_pkg::in_word_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rbd_pkg::out_word_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [rbd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [rbd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    bit calm = 1'b0;
    bit hold_req = 1'b0;
    int sent = 0;
    int cycle_count = 0;
    reverse_delay_board board;

    reverse_block_delay #(.BUFFER_DEPTH(DEPTH)) dut (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) board.set_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) board.record_word(s_data);
            if (m_valid && m_ready) board.check_word(m_data);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Result side: random stalls, one long hold-off on request.
    initial begin
        bit held;
        held = 1'b0;
        forever begin
            if (hold_req && !held) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                held = 1'b1;
            end else if (calm || $urandom_range(0, 99) < 60) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge aclk);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL reverse_block_delay");
        $finish;
    end

    function automatic logic [rbd_pkg::SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return rbd_pkg::SAMPLE_W'($urandom);
        if (r < 85) begin
            case ($urandom_range(0, 4))
                0: return PEAK_POS;
                1: return PEAK_NEG;
                2: return '0;
                3: return '1;
                default: return 24'd1;
            endcase
        end
        return rbd_pkg::SAMPLE_W'($urandom_range(0, 2000) - 1000);
    endfunction

    function automatic rbd_pkg::in_word_t pair(logic [rbd_pkg::SAMPLE_W-1:0] l,
                                               logic [rbd_pkg::SAMPLE_W-1:0] r);
        rbd_pkg::in_word_t w;
        w.in_left = l;
        w.in_right = r;
        return w;
    endfunction

    function automatic logic [rbd_pkg::CFG_DATA_W-1:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return rbd_pkg::CFG_DATA_W'($urandom_range(1, 16));
        if (r < 80) return rbd_pkg::CFG_DATA_W'($urandom_range(17, 300));
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 18'd1;
            2: return rbd_pkg::CFG_DATA_W'(DEPTH);
            3: return rbd_pkg::CFG_DATA_W'(DEPTH + 1);
            4: return '1;
            default: return rbd_pkg::CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [rbd_pkg::CFG_DATA_W-1:0] pick_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return rbd_pkg::CFG_DATA_W'($urandom_range(0, 31129));
        if (r < 80) begin
            case ($urandom_range(0, 2))
                0: return '0;
                1: return 18'd31129;
                default: return 18'h7FFF;
            endcase
        end
        return rbd_pkg::CFG_DATA_W'($urandom);
    endfunction

    function automatic logic [rbd_pkg::CFG_DATA_W-1:0] pick_mix();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return rbd_pkg::CFG_DATA_W'($urandom_range(0, 32768));
        if (r < 75) begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return 18'd32768;
                2: return 18'd32769;
                default: return 18'hFFFF;
            endcase
        end
        return rbd_pkg::CFG_DATA_W'($urandom);
    endfunction

    task automatic send_word(rbd_pkg::in_word_t w);
        int gap;
        gap = pick_gap();
        if (!calm && gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    // Drop valid and hold until every predicted word has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.pending_out.size() != 0);
    endtask

    task automatic write_reg(logic [rbd_pkg::CFG_IDX_W-1:0] idx,
                             logic [rbd_pkg::CFG_DATA_W-1:0] data, bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (last) cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [rbd_pkg::CFG_DATA_W-1:0] len,
                             logic [rbd_pkg::CFG_DATA_W-1:0] fb,
                             logic [rbd_pkg::CFG_DATA_W-1:0] mix, bit spare);
        // shrink the block when a longer one would play back unrecorded entries
        if (!board.fits(len)) len = rbd_pkg::CFG_DATA_W'(board.fill + 1);
        write_reg(rbd_pkg::CFG_BLOCK_SIZE, len, 1'b0);
        write_reg(rbd_pkg::CFG_FEEDBACK_GAIN, fb, 1'b0);
        write_reg(rbd_pkg::CFG_MIX_LEVEL, mix, !spare);
        if (spare) write_reg(CFG_SPARE, rbd_pkg::CFG_DATA_W'($urandom), 1'b1);
    endtask

    initial begin
        int phase;
        int n;
        board = new(DEPTH);
        wait (aresetn);
        @(posedge aclk);

        // reset settings: no block filled yet, wet stays zero
        send_word(pair(PEAK_POS, PEAK_NEG));
        send_word(pair(PEAK_NEG, PEAK_POS));
        send_word(pair('0, '0));
        send_word(pair('1, 24'd1));
        send_word(pair(24'hAAAAAA, 24'h555555));
        send_word(pair(24'h555555, 24'hAAAAAA));
        send_word(pair(PEAK_POS, PEAK_POS));
        send_word(pair(PEAK_NEG, PEAK_NEG));
        wait_drained();

        // one-sample blocks, full feedback, mix above unity
        configure(18'd1, 18'h7FFF, 18'hFFFF, 1'b0);
        send_word(pair(PEAK_POS, PEAK_POS));
        send_word(pair(PEAK_POS, PEAK_POS));
        send_word(pair(PEAK_NEG, PEAK_NEG));
        send_word(pair(PEAK_NEG, PEAK_NEG));
        send_word(pair(24'd1, '1));
        wait_drained();

        // zero block size, no feedback, dry only
        configure('0, '0, '0, 1'b0);
        send_word(pair(PEAK_POS, PEAK_NEG));
        send_word(pair(24'd123, -24'sd456));
        wait_drained();

        configure(18'd4, 18'd31129, 18'd32768, 1'b1);
        repeat (8) send_word(pair(pick_sample(), pick_sample()));
        wait_drained();

        phase = 0;
        while (sent < ITEM_TARGET) begin
            configure(pick_len(), pick_gain(), pick_mix(), $urandom_range(0, 3) == 0);
            calm = ($urandom_range(0, 4) == 0);
            n = $urandom_range(8, 50);
            // stall the result side long enough to back up the input
            if (phase == 2) begin
                calm = 1'b1;
                hold_req = 1'b1;
                n = 60;
            end
            repeat (n) send_word(pair(pick_sample(), pick_sample()));
            wait_drained();
            phase++;
        end

        calm = 1'b0;
        repeat (LATENCY + 5) @(posedge aclk);
        if (board.errors == 0 && board.pending_out.size() == 0) begin
            $display("PASS reverse_block_delay");
        end else begin
            $display("FAIL reverse_block_delay");
        end
        $finish;
    end

endmodule
